@@ hw/rtl/tefc_pkg.sv @@
// Shared types and constants for the thermal expansion flow correction block.
// No dependencies; every other file of the block imports this package.
package tefc_pkg;

    // One input word and one result word.
    typedef struct packed {
        logic signed [15:0] temperature;
        logic signed [31:0] raw_flow;
    } t_in;

    typedef struct packed {
        logic signed [31:0] corrected_flow;
        logic        [1:0]  clamp_status;
    } t_out;

    // Configuration register indexes (word address).
    localparam logic [2:0] REG_DENSITY  = 3'd0;
    localparam logic [2:0] REG_COEF_LIN = 3'd1;
    localparam logic [2:0] REG_COEF_SQ  = 3'd2;
    localparam logic [2:0] REG_GAIN     = 3'd3;
    localparam logic [2:0] REG_LIM_HI   = 3'd4;
    localparam logic [2:0] REG_LIM_LO   = 3'd5;

    // Clamp status codes.
    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_HIGH = 2'd1;
    localparam logic [1:0] CLAMP_LOW  = 2'd2;

    // Alpha divider sequencer.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LIN,
        DIV_SQA,
        DIV_SQB
    } t_div_state;

    localparam int unsigned DIV_STEPS = 80;

    // Fixed-point constants.
    localparam logic signed [16:0] DT_OFFSET = 17'sd3840;       // 15.0 in Q8.8
    localparam logic [79:0]        U_LIMIT   = 80'h4000_0000_0000; // 64.0 in Q.40
    localparam logic signed [47:0] W_LIMIT   = 48'sh16_0000_0000;  // 22.0 in Q.32
    localparam logic [30:0]        LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
    localparam logic [32:0]        ONE_Q32   = 33'h1_0000_0000;
    localparam logic [21:0]        DIV5_HI   = 22'd3355443;     // (2^24-1)/5
    localparam logic [25:0]        DIV5_MAG  = 26'd53687092;    // ceil(2^28/5)

    // 2^(-i/4) in Q1.30.
    localparam logic [30:0] POW2_QTR [0:3] = '{
        31'd1073741824, 31'd902905651, 31'd759250125, 31'd638450708
    };

    // Reciprocals for the Horner divides by 7 down to 1 (30-bit dividend).
    localparam logic [30:0] H_MAGIC [0:6] = '{
        31'd1227133514, 31'd1431655766, 31'd1717986919, 31'd1073741825,
        31'd1431655766, 31'd1073741825, 31'd1073741825
    };
    localparam int unsigned H_SHIFT [0:6] = '{33, 33, 33, 32, 32, 31, 30};

    // Sideband that rides along the exp polynomial stages.
    typedef struct packed {
        logic [29:0] t;
        logic [1:0]  idx;
        logic [17:0] n;
        logic        zero;
    } t_hcar;

endpackage

@@ hw/rtl/thermal_expansion_flow_correction_top.sv @@
// Top level of the thermal expansion flow correction block: APB register file,
// alpha divider and the 32-stage correction pipeline. Depends on tefc_pkg.
//
// Usage
//   Config: APB port, six 32-bit registers at byte addresses 0x00..0x14
//   (density, coef_linear, coef_square, gain, limit_high, limit_low). pready is
//   tied high; reads return the register value.
//   Input: drive a word on i_in with i_start; it is taken at an edge where
//   i_start is high and o_busy is low. One word may be taken every cycle.
//   Output: o_valid strobes for one cycle with the corrected word on o_out,
//   once it has passed through the whole pipeline. The receiver cannot hold the
//   output off, so there is no backpressure anywhere in the pipeline.
//   Throughput is one word per cycle while o_busy is low, set by the fully pipelined datapath.
//   Alpha depends on configuration only: a write to density, coef_linear or
//   coef_square starts a bit-serial divider (one quotient bit a cycle, three
//   80-bit divisions) unless density is zero, and keeps o_busy high until alpha is updated.
//   Reset clears the pipeline valid bits, loads the register defaults and sets
//   alpha to zero (density resets to zero), so no divider pass follows reset.
module thermal_expansion_flow_correction_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  tefc_pkg::t_in   i_in,
    output logic            o_valid,
    output tefc_pkg::t_out  o_out,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import tefc_pkg::*;

    localparam int NST  = 32;   // pipeline depth
    localparam int SIDE = 30;   // stages that carry the flow magnitude

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [31:0] r_density, r_coef_lin, r_coef_sq, r_gain, r_lim_hi, r_lim_lo;
    logic        w_cfg_wr;
    logic [2:0]  w_idx;

    assign pready   = 1'b1;
    assign w_idx    = paddr[4:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density  <= 32'd0;
            r_coef_lin <= 32'd65536;
            r_coef_sq  <= 32'd65536;
            r_gain     <= 32'd16777216;
            r_lim_hi   <= 32'h7FFF_FFFF;
            r_lim_lo   <= 32'h8000_0000;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_DENSITY:  r_density  <= pwdata;
                REG_COEF_LIN: r_coef_lin <= pwdata;
                REG_COEF_SQ:  r_coef_sq  <= pwdata;
                REG_GAIN:     r_gain     <= pwdata;
                REG_LIM_HI:   r_lim_hi   <= pwdata;
                REG_LIM_LO:   r_lim_lo   <= pwdata;
                default: ;  // unmapped words are dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DENSITY:  prdata = r_density;
            REG_COEF_LIN: prdata = r_coef_lin;
            REG_COEF_SQ:  prdata = r_coef_sq;
            REG_GAIN:     prdata = r_gain;
            REG_LIM_HI:   prdata = r_lim_hi;
            REG_LIM_LO:   prdata = r_lim_lo;
            default:      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Alpha divider: restoring, one quotient bit per cycle.
    //   LIN: t1 = (coef_linear << 32) / density
    //   SQA: a  = (coef_square << 32) / density
    //   SQB: t2 = (a << 16) / density, saturating at 64 bits
    //   alpha = t1 + t2, saturating.
    // ------------------------------------------------------------------
    t_div_state  r_dstate, n_dstate;
    logic        r_kick;
    logic [6:0]  r_cnt, n_cnt;
    logic [79:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic        r_ovf, n_ovf;
    logic [63:0] r_t1, n_t1;
    logic [63:0] r_alpha, n_alpha;

    logic        w_last;
    logic [32:0] w_rem_sh;
    logic        w_ge;
    logic [63:0] w_qfin;
    logic [64:0] w_asum;

    assign o_busy = r_kick || (r_dstate != DIV_IDLE);
    assign w_last = (r_cnt == 7'(DIV_STEPS - 1));

    always_comb begin
        n_dstate = r_dstate;
        priority if (r_kick) begin
            n_dstate = (r_density != 32'd0) ? DIV_LIN : DIV_IDLE;
        end else begin
            unique case (r_dstate)
                DIV_IDLE: n_dstate = DIV_IDLE;
                DIV_LIN:  if (w_last) n_dstate = DIV_SQA;
                DIV_SQA:  if (w_last) n_dstate = DIV_SQB;
                DIV_SQB:  if (w_last) n_dstate = DIV_IDLE;
                default:  n_dstate = DIV_IDLE;
            endcase
        end
    end

    always_comb begin
        w_rem_sh = {r_rem[31:0], r_num[79]};
        w_ge     = (w_rem_sh >= {1'b0, r_density});
        n_num    = r_num;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_ovf    = r_ovf;
        n_cnt    = r_cnt;
        n_t1     = r_t1;
        n_alpha  = r_alpha;
        w_qfin   = (r_ovf || r_quo[63]) ? '1 : {r_quo[62:0], w_ge};
        w_asum   = {1'b0, r_t1} + {1'b0, w_qfin};
        priority if (r_kick) begin
            n_num = {16'd0, r_coef_lin, 32'd0};
            n_rem = '0;
            n_quo = '0;
            n_ovf = 1'b0;
            n_cnt = '0;
            if (r_density == 32'd0) n_alpha = '0;
        end else if (r_dstate != DIV_IDLE) begin
            n_num = {r_num[78:0], 1'b0};
            n_rem = w_ge ? (w_rem_sh - {1'b0, r_density}) : w_rem_sh;
            n_quo = {r_quo[62:0], w_ge};
            n_ovf = r_ovf || r_quo[63];
            n_cnt = r_cnt + 7'd1;
            if (w_last) begin
                n_rem = '0;
                n_quo = '0;
                n_ovf = 1'b0;
                n_cnt = '0;
                unique case (r_dstate)
                    DIV_LIN: begin
                        n_t1  = w_qfin;
                        n_num = {16'd0, r_coef_sq, 32'd0};
                    end
                    DIV_SQA: n_num = {w_qfin, 16'd0};
                    DIV_SQB: n_alpha = w_asum[64] ? '1 : w_asum[63:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstate <= DIV_IDLE;
            r_kick   <= 1'b0;
            r_cnt    <= '0;
            r_alpha  <= '0;
        end else begin
            r_dstate <= n_dstate;
            r_kick   <= w_cfg_wr && (w_idx == REG_DENSITY || w_idx == REG_COEF_LIN ||
                                     w_idx == REG_COEF_SQ);
            r_cnt    <= n_cnt;
            r_alpha  <= n_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_ovf <= n_ovf;
        r_t1  <= n_t1;
    end

    // ------------------------------------------------------------------
    // Correction pipeline
    // ------------------------------------------------------------------
    logic           w_acc;
    logic [NST-1:0] r_vld;
    logic           r_fneg [0:SIDE-1];
    logic [31:0]    r_fmag [0:SIDE-1];

    assign w_acc = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[NST-2:0], w_acc};
    end

    // flow sign and magnitude travel alongside
    always_ff @(posedge i_clk) begin
        r_fneg[0] <= i_in.raw_flow[31];
        r_fmag[0] <= i_in.raw_flow[31] ? 32'(-i_in.raw_flow) : i_in.raw_flow;
        for (int i = 1; i < SIDE; i++) begin
            r_fneg[i] <= r_fneg[i-1];
            r_fmag[i] <= r_fmag[i-1];
        end
    end

    // stage 0: dT = temperature - 15
    logic signed [16:0] w_dt;
    logic [15:0]        r0_dmag;
    logic               r0_dtpos;
    assign w_dt = 17'(i_in.temperature) - DT_OFFSET;
    always_ff @(posedge i_clk) begin
        r0_dmag  <= w_dt[16] ? 16'(-w_dt) : w_dt[15:0];
        r0_dtpos <= !w_dt[16] && (w_dt != 17'sd0);
    end

    // stage 1: |u| = alpha * |dT|, in two 32x16 halves
    logic [47:0] r1_ph, r1_pl;
    logic        r1_dtpos;
    always_ff @(posedge i_clk) begin
        r1_ph    <= r_alpha[63:32] * r0_dmag;
        r1_pl    <= r_alpha[31:0] * r0_dmag;
        r1_dtpos <= r0_dtpos;
    end

    // stage 2: merge halves, flag a huge exponent
    logic [79:0] w_mag80;
    logic [46:0] r2_mag;
    logic        r2_big, r2_dtpos;
    assign w_mag80 = {r1_ph, 32'd0} + {32'd0, r1_pl};
    always_ff @(posedge i_clk) begin
        r2_mag   <= w_mag80[46:0];
        r2_big   <= (w_mag80 > U_LIMIT);
        r2_dtpos <= r1_dtpos;
    end

    // stage 3: u24 squared
    logic [61:0] r3_sq;
    logic [38:0] r3_u32;
    logic        r3_big, r3_dtpos;
    always_ff @(posedge i_clk) begin
        r3_sq    <= r2_mag[46:16] * r2_mag[46:16];
        r3_u32   <= r2_mag[46:8];
        r3_big   <= r2_big;
        r3_dtpos <= r2_dtpos;
    end

    // stage 4: 4*sq/5 split as xh*(2^24-1)/5 + (xh+xl)/5
    logic [47:0] w_x;
    logic [24:0] w_s;
    logic [45:0] r4_p1;
    logic [50:0] r4_p2;
    logic [38:0] r4_u32;
    logic        r4_big, r4_dtpos;
    assign w_x = {r3_sq[61:16], 2'b00};
    assign w_s = {1'b0, w_x[47:24]} + {1'b0, w_x[23:0]};
    always_ff @(posedge i_clk) begin
        r4_p1    <= w_x[47:24] * DIV5_HI;
        r4_p2    <= w_s * DIV5_MAG;
        r4_u32   <= r3_u32;
        r4_big   <= r3_big;
        r4_dtpos <= r3_dtpos;
    end

    // stage 5: q
    logic [45:0] r5_q;
    logic [38:0] r5_u32;
    logic        r5_big, r5_dtpos;
    always_ff @(posedge i_clk) begin
        r5_q     <= r4_p1 + 46'(r4_p2[50:28]);
        r5_u32   <= r4_u32;
        r5_big   <= r4_big;
        r5_dtpos <= r4_dtpos;
    end

    // stage 6: w = -exponent
    logic signed [47:0] r6_w;
    logic               r6_big;
    always_ff @(posedge i_clk) begin
        r6_w   <= r5_dtpos ? signed'({2'b00, r5_q} + {9'd0, r5_u32})
                           : signed'({2'b00, r5_q} - {9'd0, r5_u32});
        r6_big <= r5_big;
    end

    // stage 7: limit check, |w|
    logic [46:0] r7_m;
    logic        r7_wneg, r7_zero;
    always_ff @(posedge i_clk) begin
        r7_m    <= r6_w[47] ? 47'(-r6_w) : r6_w[46:0];
        r7_wneg <= r6_w[47];
        r7_zero <= r6_big || (r6_w >= W_LIMIT);
    end

    // stage 8: |w| * log2(e)
    logic [45:0] r8_ph;
    logic [62:0] r8_pl;
    logic        r8_wneg, r8_zero;
    always_ff @(posedge i_clk) begin
        r8_ph   <= r7_m[46:32] * LOG2E_Q30;
        r8_pl   <= r7_m[31:0] * LOG2E_Q30;
        r8_wneg <= r7_wneg;
        r8_zero <= r7_zero;
    end

    // stage 9: z = 1 + w*log2(e)
    logic [48:0] w_ml;
    logic [49:0] r9_z;
    logic        r9_zero;
    assign w_ml = {1'b0, r8_ph, 2'b00} + 49'(r8_pl[62:30]);
    always_ff @(posedge i_clk) begin
        r9_z    <= r8_wneg ? (50'(ONE_Q32) - {1'b0, w_ml}) : (50'(ONE_Q32) + {1'b0, w_ml});
        r9_zero <= r8_zero;
    end

    // stage 10: t = r * ln2
    logic [61:0] r10_tp;
    t_hcar       r10_car;
    always_ff @(posedge i_clk) begin
        r10_tp       <= r9_z[29:0] * LN2_Q32;
        r10_car.t    <= '0;
        r10_car.idx  <= r9_z[31:30];
        r10_car.n    <= r9_z[49:32];
        r10_car.zero <= r9_zero;
    end

    // stages 11..24: Horner chain p = 1 - t*p/k, k = 7 down to 1
    logic [29:0] r_hx  [0:6];
    logic [60:0] r_hy  [0:6];
    t_hcar       r_hca [0:6];
    t_hcar       r_hcb [0:6];
    logic [32:0] w_hp  [0:7];
    t_hcar       w_hin [0:6];

    assign w_hp[0] = ONE_Q32;
    always_comb begin
        w_hin[0]   = r10_car;
        w_hin[0].t = r10_tp[61:32];
    end

    for (genvar s = 0; s < 7; s++) begin : g_horner
        logic [61:0] w_tp;
        assign w_tp        = w_hin[s].t * w_hp[s][31:0];
        assign w_hp[s+1]   = ONE_Q32 - 33'(r_hy[s] >> H_SHIFT[s]);
        if (s > 0) begin : g_link
            assign w_hin[s] = r_hcb[s-1];
        end
        always_ff @(posedge i_clk) begin
            r_hx[s]  <= w_hp[s][32] ? w_hin[s].t : w_tp[61:32];
            r_hca[s] <= w_hin[s];
            r_hy[s]  <= r_hx[s] * H_MAGIC[s];
            r_hcb[s] <= r_hca[s];
        end
    end

    // stage 25: f = 2^(-idx/4) * p
    logic [62:0] w_fp;
    logic [30:0] w_tab;
    logic [30:0] r25_f;
    logic [17:0] r25_n;
    logic        r25_zero;
    assign w_tab = POW2_QTR[r_hcb[6].idx];
    assign w_fp  = w_tab * w_hp[7][31:0];
    always_ff @(posedge i_clk) begin
        r25_f    <= w_hp[7][32] ? w_tab : w_fp[62:32];
        r25_n    <= r_hcb[6].n;
        r25_zero <= r_hcb[6].zero;
    end

    // stage 26: scale by 2^(1-n)
    logic [17:0] w_nm1;
    logic [31:0] r26_fac;
    assign w_nm1 = r25_n - 18'd1;
    always_ff @(posedge i_clk) begin
        if (r25_zero)               r26_fac <= '0;
        else if (r25_n == 18'd0)    r26_fac <= {r25_f, 1'b0};
        else if (w_nm1 >= 18'd31)   r26_fac <= '0;
        else                        r26_fac <= {1'b0, r25_f} >> w_nm1[4:0];
    end

    // stage 27: |gain| * factor, to Q.30
    logic [31:0] w_gmag;
    logic [63:0] w_gp;
    logic [39:0] r27_a;
    assign w_gmag = r_gain[31] ? 32'(-r_gain) : r_gain;
    assign w_gp   = w_gmag * r26_fac;
    always_ff @(posedge i_clk) begin
        r27_a <= w_gp[63:24];
    end

    // stage 28: times |flow|, in integer and fraction parts
    logic [41:0] r28_ph;
    logic [61:0] r28_pl;
    always_ff @(posedge i_clk) begin
        r28_ph <= r27_a[39:30] * r_fmag[27];
        r28_pl <= r27_a[29:0] * r_fmag[27];
    end

    // stage 29: magnitude in Q.16
    logic [42:0] r29_mag;
    always_ff @(posedge i_clk) begin
        r29_mag <= {1'b0, r28_ph} + 43'(r28_pl[61:30]);
    end

    // stage 30: apply sign
    logic signed [43:0] r30_res;
    always_ff @(posedge i_clk) begin
        r30_res <= (r_fneg[29] != r_gain[31]) ? -signed'({1'b0, r29_mag})
                                              : signed'({1'b0, r29_mag});
    end

    // stage 31: clamp high then low; low wins if the limits cross
    logic signed [43:0] w_hi, w_lo, w_res;
    logic [1:0]         w_st;
    t_out               r_out;
    assign w_hi = 44'(signed'(r_lim_hi));
    assign w_lo = 44'(signed'(r_lim_lo));
    always_comb begin
        w_res = r30_res;
        w_st  = CLAMP_NONE;
        if (w_res > w_hi) begin
            w_res = w_hi;
            w_st  = CLAMP_HIGH;
        end
        if (w_res < w_lo) begin
            w_res = w_lo;
            w_st  = CLAMP_LOW;
        end
    end
    always_ff @(posedge i_clk) begin
        r_out.corrected_flow <= w_res[31:0];
        r_out.clamp_status   <= w_st;
    end

    assign o_valid = r_vld[NST-1];
    assign o_out   = r_out;

`ifndef NO_ASSERTIONS
    // every accepted word comes out with o_valid at the end of the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##NST o_valid)
        else $error("word lost in pipeline");

    // a density or coef_square write must raise o_busy to hold off input
    a_kick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && (w_idx == REG_DENSITY || w_idx == REG_COEF_SQ)) |=> o_busy)
        else $error("input open while alpha stale");

    // divider step counter parks at zero when idle
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dstate == DIV_IDLE) |-> (r_cnt == 7'd0))
        else $error("divider counter running while idle");

    // clamp status agrees with the value delivered
    a_clamp_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.clamp_status == CLAMP_LOW) |-> (o_out.corrected_flow == r_lim_lo))
        else $error("low clamp value mismatch");

    a_clamp_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.clamp_status == CLAMP_HIGH) |-> (o_out.corrected_flow == r_lim_hi))
        else $error("high clamp value mismatch");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for thermal_expansion_flow_correction_top.
// Depends on tefc_pkg; predicts each corrected word in a scoreboard class.
module testbench;
    import tefc_pkg::*;

    // Scoreboard: holds the register copy, predicts the corrected word for
    // each accepted sample and checks results in order of arrival.
    class flow_scoreboard;
        logic [31:0] density, coef_linear, coef_square, gain, limit_high, limit_low;
        t_out        expected_words[$];
        int          mismatches;

        function new();
            density     = 32'd0;
            coef_linear = 32'd65536;
            coef_square = 32'd65536;
            gain        = 32'd16777216;
            limit_high  = 32'h7FFF_FFFF;
            limit_low   = 32'h8000_0000;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_DENSITY:  density = val;
                REG_COEF_LIN: coef_linear = val;
                REG_COEF_SQ:  coef_square = val;
                REG_GAIN:     gain = val;
                REG_LIM_HI:   limit_high = val;
                REG_LIM_LO:   limit_low = val;
                default: ;
            endcase
        endfunction

        // floor(num * 2^sh / d), saturating at all ones
        function longint unsigned scaled_quotient(longint unsigned num, int sh,
                                                  longint unsigned d);
            longint unsigned q, r;
            q = num / d;
            r = num % d;
            for (int i = 0; i < sh; i++) begin
                if (q[63]) return 64'hFFFF_FFFF_FFFF_FFFF;
                q = q << 1;
                r = r << 1;
                if (r >= d) begin
                    r = r - d;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function longint unsigned times_log2e(longint unsigned m);
            longint unsigned hi, lo;
            hi = m >> 32;
            lo = m & 64'hFFFF_FFFF;
            return ((hi * 64'd1549082005) << 2) + ((lo * 64'd1549082005) >> 30);
        endfunction

        // Correction factor as unsigned Q2.30.
        function longint unsigned correction_factor(logic signed [15:0] temp);
            longint unsigned alpha, d, t1, t2, dmag, mag, u32, u24, sq, q;
            longint unsigned z, g, r, t, p, f;
            longint signed   w;
            int              dt;
            int unsigned     n;
            longint unsigned pow2_qtr[4];
            pow2_qtr = '{64'd1073741824, 64'd902905651, 64'd759250125, 64'd638450708};
            alpha = 0;
            if (density != 0) begin
                d  = density;
                t1 = ({32'd0, coef_linear} << 32) / d;
                t2 = scaled_quotient(({32'd0, coef_square} << 32) / d, 16, d);
                alpha = (t1 > 64'hFFFF_FFFF_FFFF_FFFF - t2) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                            : t1 + t2;
            end
            dt   = int'(temp) - 3840;
            dmag = (dt < 0) ? longint'(-dt) : longint'(dt);
            // huge exponent: factor underflows to zero
            if (dmag != 0 && alpha > (64'h4000_0000_0000 / dmag)) return 0;
            mag = alpha * dmag;
            u32 = mag >> 8;
            u24 = mag >> 16;
            sq  = (u24 * u24) >> 16;
            q   = sq * 4 / 5;
            w   = (dt > 0) ? longint'(u32 + q) : longint'(q) - longint'(u32);
            if (w >= (longint'(22) << 32)) return 0;
            z = (w >= 0) ? 64'h1_0000_0000 + times_log2e(w)
                         : 64'h1_0000_0000 - times_log2e(-w);
            n = z[63:32];
            g = z & 64'hFFFF_FFFF;
            r = g & 64'h3FFF_FFFF;
            t = (r * 64'd2977044472) >> 32;
            p = 64'h1_0000_0000;
            for (int k = 7; k >= 1; k--)
                p = 64'h1_0000_0000 - ((t * p) >> 32) / k;
            f = (pow2_qtr[g[31:30]] * p) >> 32;
            if (n == 0) return f << 1;
            if (n - 32'd1 >= 32'd63) return 0;
            return f >> (n - 32'd1);
        endfunction

        function void note_sample(t_in s);
            longint signed   flow, gs, hi, lo, res;
            longint unsigned factor, gmag, fmag, a, mag;
            t_out            e;
            flow   = longint'(s.raw_flow);
            gs     = longint'($signed(gain));
            hi     = longint'($signed(limit_high));
            lo     = longint'($signed(limit_low));
            factor = correction_factor(s.temperature);
            gmag   = (gs < 0) ? -gs : gs;
            fmag   = (flow < 0) ? -flow : flow;
            a      = (gmag * factor) >> 24;
            mag    = (a >> 30) * fmag + (((a & 64'h3FFF_FFFF) * fmag) >> 30);
            res    = ((gs < 0) != (flow < 0)) ? -longint'(mag) : longint'(mag);
            e.clamp_status = CLAMP_NONE;
            if (res > hi) begin
                res = hi;
                e.clamp_status = CLAMP_HIGH;
            end
            // low limit applied last, so it wins when the limits cross
            if (res < lo) begin
                res = lo;
                e.clamp_status = CLAMP_LOW;
            end
            e.corrected_flow = res[31:0];
            expected_words.push_back(e);
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void check_word(t_out got);
            t_out e;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            e = expected_words.pop_front();
            if (got.corrected_flow !== e.corrected_flow)
                report($sformatf("corrected_flow %h, expected %h",
                                 got.corrected_flow, e.corrected_flow));
            if (got.clamp_status !== e.clamp_status)
                report($sformatf("clamp_status %0d, expected %0d",
                                 got.clamp_status, e.clamp_status));
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_start, o_busy, o_valid;
    t_in         i_in;
    t_out        o_out;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    flow_scoreboard sb;
    int             idle_cycles;

    thermal_expansion_flow_correction_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_in(i_in), .o_valid(o_valid), .o_out(o_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Check every result word as it strobes past.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_word(o_out);
    end

    // Watchdog: count cycles in which no word moves either way.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 3000) begin
            $display("watchdog expired");
            $display("thermal_expansion_flow_correction_top test failed");
            $finish;
        end
    end

    // Wait out any divider pass, then write one register over APB.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
        while (o_busy) @(negedge i_clk);
    endtask

    // Drop start, hold until every expected word has come, then let the pipe drain.
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] dens, logic [31:0] cl, logic [31:0] cs,
                             logic [31:0] g, logic [31:0] hi, logic [31:0] lo);
        drain();
        write_reg(REG_DENSITY, dens);
        write_reg(REG_COEF_LIN, cl);
        write_reg(REG_COEF_SQ, cs);
        write_reg(REG_GAIN, g);
        write_reg(REG_LIM_HI, hi);
        write_reg(REG_LIM_LO, lo);
    endtask

    // Offer one sample after a gap; it is taken at the first edge with busy low.
    task automatic send_sample(logic signed [15:0] temp, logic signed [31:0] flow,
                               int gap);
        t_in s;
        s.temperature = temp;
        s.raw_flow    = flow;
        @(negedge i_clk);
        for (int i = 0; i < gap; i++) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        while (o_busy) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= s;
        @(posedge i_clk);
        sb.note_sample(s);
    endtask

    function automatic logic signed [15:0] pick_temp();
        // mostly plausible process temperatures, some anywhere in range
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 35000) - 2200);
    endfunction

    function automatic logic signed [31:0] pick_flow();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
        endcase
    endfunction

    task automatic random_phase(int count, bit burst);
        for (int i = 0; i < count; i++)
            send_sample(pick_temp(), pick_flow(),
                        burst ? 0 : $urandom_range(0, 18));
    endtask

    initial begin
        logic signed [15:0] dir_temp[8];
        logic signed [31:0] dir_flow[3];
        sb = new();
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: zero density, so the factor is exactly one.
        send_sample(16'sh7FFF, 32'sh7FFF_FFFF, 0);
        send_sample(16'sh8000, 32'sh8000_0000, 0);
        send_sample(16'sd3840, 32'sd0, 3);

        // Realistic oil: density 850.0, coefficients near the standard ones.
        configure(32'd850 << 16, 32'd40000, 32'd3000000, 32'd16777216,
                  32'h7FFF_FFFF, 32'h8000_0000);
        dir_temp = '{16'sh8000, 16'sh7FFF, 16'sd3840, 16'sd3841, 16'sd3839,
                     16'sd0, 16'sd25600, -16'sd1};
        dir_flow = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd65536};
        foreach (dir_temp[i])
            foreach (dir_flow[j])
                if (i * 3 + j < 20) send_sample(dir_temp[i], dir_flow[j], 0);
        random_phase(50, 1'b0);

        // Tiny density: alpha saturates, huge exponent gives zero.
        configure(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000);
        random_phase(40, 1'b1);

        // Maximum density, zero coefficients, negative full-scale gain.
        configure(32'hFFFF_FFFF, 32'd0, 32'd0, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000);
        random_phase(50, 1'b0);

        // Light fluid with large alpha; gain 4.0 and tight limits.
        configure(32'd12 << 16, 32'd65536, 32'd0, 32'd67108864,
                  32'd100 << 16, -(32'd100 << 16));
        random_phase(30, 1'b0);
        // hold off the sender until the pipeline is empty
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        random_phase(30, 1'b1);

        // Crossed limits: low clamp wins.
        configure(32'd700 << 16, 32'd20000, 32'd65536, 32'hFF00_0000,
                  -(32'd5 << 16), 32'd5 << 16);
        random_phase(50, 1'b0);

        // Random settings for the rest of the run.
        for (int ph = 0; ph < 4; ph++) begin
            configure($urandom_range(1, 1500) << 16, $urandom_range(0, 200000),
                      $urandom, $urandom, $urandom, $urandom);
            random_phase(50, ph[0]);
        end

        @(negedge i_clk);
        i_start <= 1'b0;
        drain();
        if (sb.mismatches == 0) begin
            $display("thermal_expansion_flow_correction_top test passed");
        end else begin
            $display("thermal_expansion_flow_correction_top test failed");
        end
        $finish;
    end
endmodule
